/* hw/rtl/mpfa_pkg.sv */
// Package for the modular prime field ALU: operation codes and the packed
// control word between the sequencer and the remainder unit. No dependencies.
`timescale 1ns / 1ps
package mpfa_pkg;
  typedef enum logic [2:0] {
    OP_REDUCE   = 3'd0,
    OP_ADD      = 3'd1,
    OP_SUB      = 3'd2,
    OP_NEG      = 3'd3,
    OP_MUL      = 3'd4,
    OP_POW      = 3'd5,
    OP_INV      = 3'd6,
    OP_DIV      = 3'd7
  } op_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } rem_ctl_t;
endpackage

/* hw/rtl/mpfa_rem.sv */
// Iterative remainder unit: one quotient bit per cycle (restoring division).
// Depends on mpfa_pkg for the control struct.
`timescale 1ns / 1ps
module mpfa_rem #(
  parameter int MW = 31,
  parameter int NW = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [MW-1:0]       modulus,
  output mpfa_pkg::rem_ctl_t  ctl,
  output logic [MW-1:0]       rem
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] shift;
  logic [MW:0]   part;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [MW+1:0] trial;
  logic [MW:0]   part_next;

  always_comb begin
    trial = {part, shift[NW-1]} - {2'b00, modulus};
    if (!trial[MW+1]) begin
      part_next = trial[MW:0];
    end else begin
      part_next = {part[MW-1:0], shift[NW-1]};
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      shift <= num;
      part  <= '0;
      count <= CW'(NW);
    end else if (busy) begin
      part  <= part_next;
      shift <= shift << 1;
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rem       = part[MW-1:0];
  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> $past(busy)) else $error("remainder done without work");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> ({1'b0, rem} < {1'b0, modulus})) else $error("remainder out of range");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("restart while busy");
endmodule

/* hw/rtl/modular_prime_field_alu.sv */
// Top level of the modular prime field ALU: sequencer, modulus register,
// output register. Uses mpfa_pkg and mpfa_rem.
//
// channel | dir | fields (low bit up)
// s_axis  | in  | tuser=kind; tdata=left(31) right(31) exponent(64) signed_raw(64)
// m_axis  | out | tdata=result(31)
// cfg     | in  | cfg_we / cfg_wdata = modulus
// One item at a time; each remainder runs in mpfa_rem while the sequencer waits.
// Power: 64 squarings and up to 64 multiplies at defaults; inverse and divide
// use the same ladder with exponent modulus-2, and divide then multiplies once more.
// Synchronous reset clears control; modulus resets to 1000000007.
// s_axis_tready is low while an item is in work or a result is held.
`timescale 1ns / 1ps
module modular_prime_field_alu #(
  parameter int MODULUS_WIDTH  = 31,
  parameter int EXPONENT_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [MODULUS_WIDTH-1:0] cfg_wdata,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // left_operand[30:0], right_operand[61:31], exponent[125:62], signed_raw[189:126]
  input  logic [191:0]             s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]               s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // result[MODULUS_WIDTH-1:0], zero filled
  output logic [((MODULUS_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  localparam int MW = MODULUS_WIDTH;
  localparam int EW = EXPONENT_WIDTH;
  localparam int NW = 64;
  localparam int BW = $clog2(EW + 1);
  localparam int OW = ((MW + 7) / 8) * 8;
  localparam logic [30:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_RED_B, S_RAW, S_FAST, S_MUL, S_POW_SQ, S_POW_ML,
    S_DIV_ML, S_WAIT, S_OUT
  } state_t;

  state_t        state;
  state_t        ret;
  mpfa_pkg::op_t kind;
  logic [MW-1:0] modulus;
  logic [MW-1:0] a;
  logic [MW-1:0] b;
  logic [30:0]   b_raw;
  logic [MW-1:0] acc;
  logic [EW-1:0] e;
  logic [BW-1:0] bit_cnt;
  logic          raw_neg;
  logic [MW-1:0] res;
  logic          rem_start;
  logic [NW-1:0] rem_num;
  mpfa_pkg::rem_ctl_t rem_ctl;
  logic [MW-1:0] rem_val;
  logic [MW:0]   sum;
  logic [MW:0]   dif;
  logic [MW-1:0] fast;

  mpfa_rem #(.MW(MW), .NW(NW)) u_rem (
    .clk(clk), .rst(rst), .start(rem_start), .num(rem_num),
    .modulus(modulus), .ctl(rem_ctl), .rem(rem_val)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = OW'(res);

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    dif = {1'b0, a} - {1'b0, b};
    fast = '0;
    case (kind)
      mpfa_pkg::OP_ADD: fast = (sum >= {1'b0, modulus}) ? MW'(sum - {1'b0, modulus})
                                                         : sum[MW-1:0];
      mpfa_pkg::OP_SUB: fast = dif[MW] ? MW'(dif + {1'b0, modulus}) : dif[MW-1:0];
      mpfa_pkg::OP_NEG: fast = (a == '0) ? '0 : modulus - a;
      default:          fast = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rem_start <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      modulus <= MW'(MOD_RESET);
    end else begin
      if (cfg_we) begin
        modulus <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind <= mpfa_pkg::op_t'(s_axis_tuser);
            e    <= s_axis_tdata[62 +: EW];
            if (modulus < MW'(2)) begin
              res   <= '0;
              state <= S_OUT;
            end else if (mpfa_pkg::op_t'(s_axis_tuser) == mpfa_pkg::OP_REDUCE) begin
              raw_neg   <= s_axis_tdata[189];
              rem_num   <= s_axis_tdata[189] ? (~s_axis_tdata[189:126] + 64'd1)
                                             : s_axis_tdata[189:126];
              rem_start <= 1'b1;
              ret       <= S_RAW;
              state     <= S_WAIT;
            end else begin
              rem_num   <= NW'(s_axis_tdata[30:0]);
              b_raw     <= s_axis_tdata[61:31];
              rem_start <= 1'b1;
              ret       <= S_RED_A;
              state     <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (rem_ctl.done) begin
            state <= ret;
          end
        end
        S_RAW: begin
          res   <= (raw_neg && rem_val != '0) ? modulus - rem_val : rem_val;
          state <= S_OUT;
        end
        S_RED_A: begin
          a         <= rem_val;
          rem_num   <= NW'(b_raw);
          rem_start <= 1'b1;
          ret       <= S_RED_B;
          state     <= S_WAIT;
        end
        S_RED_B: begin
          b <= (kind == mpfa_pkg::OP_DIV) ? a : rem_val;
          unique case (kind) inside
            mpfa_pkg::OP_ADD, mpfa_pkg::OP_SUB, mpfa_pkg::OP_NEG: state <= S_FAST;
            mpfa_pkg::OP_MUL: begin
              rem_num   <= NW'(a) * NW'(rem_val);
              rem_start <= 1'b1;
              ret       <= S_MUL;
              state     <= S_WAIT;
            end
            default: begin
              if (kind == mpfa_pkg::OP_INV) begin
                e <= EW'(modulus - MW'(2));
              end else if (kind == mpfa_pkg::OP_DIV) begin
                e <= EW'(modulus - MW'(2));
                a <= rem_val;
              end
              acc     <= MW'(1);
              bit_cnt <= BW'(EW);
              state   <= S_POW_SQ;
            end
          endcase
        end
        S_FAST: begin
          res   <= fast;
          state <= S_OUT;
        end
        S_MUL: begin
          res   <= rem_val;
          state <= S_OUT;
        end
        S_POW_SQ: begin
          if (bit_cnt == '0) begin
            if (kind == mpfa_pkg::OP_DIV) begin
              rem_num   <= NW'(acc) * NW'(b);
              rem_start <= 1'b1;
              ret       <= S_MUL;
              state     <= S_WAIT;
            end else begin
              res   <= acc;
              state <= S_OUT;
            end
          end else begin
            rem_num   <= NW'(acc) * NW'(acc);
            rem_start <= 1'b1;
            ret       <= S_POW_ML;
            state     <= S_WAIT;
          end
        end
        S_POW_ML: begin
          acc     <= rem_val;
          bit_cnt <= bit_cnt - 1'b1;
          e       <= e << 1;
          if (e[EW-1]) begin
            rem_num   <= NW'(rem_val) * NW'(a);
            rem_start <= 1'b1;
            ret       <= S_DIV_ML;
            state     <= S_WAIT;
          end else begin
            state <= S_POW_SQ;
          end
        end
        S_DIV_ML: begin
          acc   <= rem_val;
          state <= S_POW_SQ;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && modulus >= MW'(2)) |-> (res < modulus))
    else $error("result not below modulus");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(res)))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rem_ctl.busy |-> !s_axis_tready) else $error("ready while working");
endmodule

/* tb/mpfa_scoreboard.sv */
// Result checker for the modular prime field ALU: watches the config port and both
// streams, computes each expected residue and compares transfers. Uses mpfa_pkg.
`timescale 1ns / 1ps
module mpfa_scoreboard (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  output int           fail_count,
  output int           outstanding
);
  logic [30:0] modulus;
  logic [30:0] residues_due[$];

  function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] e,
                                            logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    for (int i = 63; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (e[i]) acc = (acc * base) % m;
    end
    return acc;
  endfunction

  function automatic logic [30:0] field_result(mpfa_pkg::op_t op, logic [191:0] d,
                                               logic [30:0] mod);
    logic [63:0] m, a, b, e, raw, mag, rem, r;
    m = {33'd0, mod};
    if (m < 2) return '0;
    a = {33'd0, d[30:0]} % m;
    b = {33'd0, d[61:31]} % m;
    e = d[125:62];
    raw = d[189:126];
    case (op)
      mpfa_pkg::OP_REDUCE: begin
        if (raw[63]) begin
          mag = ~raw + 64'd1;
          rem = mag % m;
          r = (rem != 0) ? m - rem : 64'd0;
        end else begin
          r = raw % m;
        end
      end
      mpfa_pkg::OP_ADD: begin
        r = a + b;
        if (r >= m) r = r - m;
      end
      mpfa_pkg::OP_SUB: r = (a >= b) ? a - b : a + m - b;
      mpfa_pkg::OP_NEG: r = (a != 0) ? m - a : 64'd0;
      mpfa_pkg::OP_MUL: r = (a * b) % m;
      mpfa_pkg::OP_POW: r = power_mod(a, e, m);
      mpfa_pkg::OP_INV: r = power_mod(a, m - 64'd2, m);
      default: r = (a * power_mod(b, m - 64'd2, m)) % m;
    endcase
    return r[30:0];
  endfunction

  assign outstanding = residues_due.size();

  always @(posedge clk) begin
    if (rst) begin
      modulus <= 31'd1000000007;
      residues_due.delete();
      fail_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (residues_due.size() == 0) begin
          $error("result: unexpected transfer, actual %0d", m_axis_tdata[30:0]);
          fail_count <= fail_count + 1;
        end else if (m_axis_tdata[30:0] !== residues_due[0]) begin
          $error("result: expected %0d, actual %0d", residues_due[0], m_axis_tdata[30:0]);
          fail_count <= fail_count + 1;
          void'(residues_due.pop_front());
        end else begin
          void'(residues_due.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        residues_due.push_back(field_result(mpfa_pkg::op_t'(s_axis_tuser), s_axis_tdata,
                                            modulus));
      if (cfg_we) modulus <= cfg_wdata;
    end
  end
endmodule

/* tb/tb_modular_prime_field_alu.sv */
// Testbench top for the modular prime field ALU: clock, reset, stimulus and verdict.
// Depends on mpfa_pkg, modular_prime_field_alu and mpfa_scoreboard.
`timescale 1ns / 1ps
module tb_modular_prime_field_alu;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [30:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         calm = 1'b0;
  int           hold_left = 0;
  int           fail_count;
  int           outstanding;
  logic [30:0]  cur_mod = 31'd1000000007;

  always #5 clk = ~clk;

  modular_prime_field_alu dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  mpfa_scoreboard u_scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .fail_count(fail_count), .outstanding(outstanding)
  );

  // stall the result side in bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= !rst;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_op(mpfa_pkg::op_t op, logic [30:0] left, logic [30:0] right,
                         logic [63:0] expo, logic [63:0] raw);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b00, raw, expo, right, left};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
  endtask

  function automatic logic [30:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return cur_mod - 31'd1;
      2: return 31'($urandom());
      default: return 31'($urandom_range(0, cur_mod - 1));
    endcase
  endfunction

  function automatic logic [63:0] pick_exponent();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 20));
      1: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_op(mpfa_pkg::op_t'($urandom_range(0, 7)), pick_operand(), pick_operand(),
              pick_exponent(), {$urandom(), $urandom()});
  endtask

  task automatic set_modulus(logic [30:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    cur_mod = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #100_000_000;
    $display("modular_prime_field_alu verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_op(mpfa_pkg::OP_REDUCE, '0, '0, '0, 64'h8000_0000_0000_0000);
    send_op(mpfa_pkg::OP_REDUCE, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_op(mpfa_pkg::OP_REDUCE, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(mpfa_pkg::OP_REDUCE, '0, '0, '0, -64'sd1000000007);
    send_op(mpfa_pkg::OP_REDUCE, '0, '0, '0, '0);
    send_op(mpfa_pkg::OP_ADD, 31'd1000000006, 31'd1000000006, '0, '0);
    send_op(mpfa_pkg::OP_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, '0);
    send_op(mpfa_pkg::OP_SUB, '0, 31'd1000000006, '0, '0);
    send_op(mpfa_pkg::OP_SUB, 31'd5, 31'd5, '0, '0);
    send_op(mpfa_pkg::OP_NEG, '0, '0, '0, '0);
    send_op(mpfa_pkg::OP_NEG, 31'd1, '0, '0, '0);
    send_op(mpfa_pkg::OP_MUL, 31'd1000000006, 31'd1000000006, '0, '0);
    send_op(mpfa_pkg::OP_MUL, 31'h7FFF_FFFF, 31'h7FFF_FFFE, '0, '0);
    send_op(mpfa_pkg::OP_POW, '0, '0, '0, '0);
    send_op(mpfa_pkg::OP_POW, 31'd7, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_op(mpfa_pkg::OP_POW, '0, '0, 64'd5, '0);
    send_op(mpfa_pkg::OP_INV, '0, '0, '0, '0);
    send_op(mpfa_pkg::OP_INV, 31'd2, '0, '0, '0);
    send_op(mpfa_pkg::OP_INV, 31'd1000000008, '0, '0, '0);
    send_op(mpfa_pkg::OP_DIV, 31'd9, '0, '0, '0);
    send_op(mpfa_pkg::OP_DIV, 31'd1000000006, 31'd3, '0, '0);
    send_random(25);
    set_modulus(31'd2);
    send_op(mpfa_pkg::OP_INV, '0, '0, '0, '0);
    send_op(mpfa_pkg::OP_DIV, 31'd1, '0, '0, '0);
    send_random(15);
    set_modulus(31'h7FFF_FFFF);
    send_random(15);
    set_modulus(31'd3);
    send_random(20);
    set_modulus(31'd1000);
    send_random(15);
    set_modulus(31'd1000000007);
    calm <= 1'b1;
    @(posedge clk);
    send_random(27);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("modular_prime_field_alu verification clean");
    else
      $display("modular_prime_field_alu verification failed");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/mpfa_pkg.sv
hw/rtl/mpfa_rem.sv
hw/rtl/modular_prime_field_alu.sv
tb/mpfa_scoreboard.sv
tb/tb_modular_prime_field_alu.sv
